>>> sv/mdhd_pkg.sv
package mdhd_pkg;

  localparam int unsigned CALIB_SAMPLES_DEF = 20;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned OutW    = 8;

  localparam logic [ThreshW-1:0] START_THRESH_RST = 16'd2000;
  localparam logic [ThreshW-1:0] STOP_THRESH_RST  = 16'd1000;
  localparam logic [CountW-1:0]  DEBOUNCE_RST     = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_THRESH = 2'd0,
    REG_STOP_THRESH  = 2'd1,
    REG_DEBOUNCE     = 2'd2
  } cfg_reg_e;

endpackage

>>> sv/motion_detect_hysteresis_debounce.sv
// Motion detector with hysteresis and debounce on a signed vertical acceleration stream.
// The first CalibSamples beats are averaged (truncated toward zero) into a baseline; every
// later beat is compared with the baseline by absolute difference. While idle, the block
// needs debounce_samples consecutive beats above start_threshold to go to running; while
// running, the same number of beats below stop_threshold to go back to idle. Each input beat
// gives one output beat with moving, state_changed and calibrated. A beat is taken every
// cycle and its result sits in the output register from the next cycle; the input waits only
// while an earlier result is held by a stalled output. The other exception follows the last
// calibration beat: the input stalls while the baseline passes the reciprocal multiplier
// (DIV_MUL multiplies, DIV_SCALE scales and signs). The user must write registers via the cfg
// port only while the block is idle (the block does not enforce this); index 3 is ignored.
module motion_detect_hysteresis_debounce
  import mdhd_pkg::*;
#(
  parameter int unsigned CalibSamples = CALIB_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,

  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SampleW-1:0] s_axis_tdata_i,   // [15:0] accel_z

  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OutW-1:0]    m_axis_tdata_o    // [0] moving, [1] state_changed, [2] calibrated
);

  localparam int unsigned Log2N  = $clog2(CalibSamples);
  localparam int unsigned IdxW   = $clog2(CalibSamples + 1);
  localparam int unsigned AccW   = SampleW + 1 + Log2N;
  localparam int unsigned MagW   = AccW - 1;
  localparam int unsigned Shift  = MagW + Log2N;
  localparam int unsigned RecW   = MagW + 2;
  localparam int unsigned ProdW  = MagW + RecW;
  localparam int unsigned QuotW  = SampleW + 1;
  localparam longint unsigned RecipL =
    ((longint'(1) << Shift) + longint'(CalibSamples) - 1) / longint'(CalibSamples);
  localparam logic [RecW-1:0] Recip = RecW'(RecipL);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CalibSamples - 1);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_SCALE
  } div_state_e;

  // configuration
  logic [ThreshW-1:0] start_thr_q, stop_thr_q;
  logic [CountW-1:0]  debounce_q;
  logic               cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= START_THRESH_RST;
      stop_thr_q  <= STOP_THRESH_RST;
      debounce_q  <= DEBOUNCE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_START_THRESH: start_thr_q <= cfg_data_i[ThreshW-1:0];
        REG_STOP_THRESH:  stop_thr_q  <= cfg_data_i[ThreshW-1:0];
        REG_DEBOUNCE:     debounce_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  div_state_e         div_state_q;
  logic               out_valid_q;
  logic               in_fire;

  assign s_axis_tready_o = (!out_valid_q || m_axis_tready_i) && (div_state_q == DIV_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // per-sample datapath
  logic signed [SampleW-1:0] az;
  logic signed [SampleW-1:0] baseline_q;
  logic signed [AccW-1:0]    accum_q, accum_d;
  logic [IdxW-1:0]           calib_idx_q;
  logic                      calib_q;
  logic                      motion_q, motion_d;
  logic [CountW-1:0]         qual_cnt_q, qual_cnt_d, qual_inc;
  logic signed [SampleW:0]   delta;
  logic [SampleW-1:0]        diff;
  logic                      qualifies, changed_d, calib_done;

  assign az       = s_axis_tdata_i;
  assign accum_d  = accum_q + AccW'(az);
  assign delta    = 17'(az) - 17'(baseline_q);
  assign diff     = delta[SampleW] ? SampleW'(-delta) : delta[SampleW-1:0];
  assign qualifies = motion_q ? (diff < stop_thr_q) : (diff > start_thr_q);
  assign qual_inc  = qual_cnt_q + 8'd1;
  assign calib_done = (calib_idx_q == LastIdx);

  always_comb begin
    motion_d   = motion_q;
    qual_cnt_d = qual_cnt_q;
    changed_d  = 1'b0;
    if (calib_q) begin
      if (qualifies) begin
        if (qual_inc >= debounce_q) begin
          motion_d   = !motion_q;
          qual_cnt_d = '0;
          changed_d  = 1'b1;
        end else begin
          qual_cnt_d = qual_inc;
        end
      end else begin
        qual_cnt_d = '0;
      end
    end
  end

  logic moving_q, changed_q, calibrated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      motion_q     <= 1'b0;
      qual_cnt_q   <= '0;
      calib_q      <= 1'b0;
      calib_idx_q  <= '0;
      accum_q      <= '0;
      moving_q     <= 1'b0;
      changed_q    <= 1'b0;
      calibrated_q <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (!calib_q) begin
          accum_q     <= accum_d;
          calib_idx_q <= calib_idx_q + IdxW'(1);
          calib_q     <= calib_done;
        end
        motion_q     <= motion_d;
        qual_cnt_q   <= qual_cnt_d;
        moving_q     <= motion_d;
        changed_q    <= changed_d;
        calibrated_q <= calib_q || calib_done;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, calibrated_q, changed_q, moving_q};

  // baseline = accum / CalibSamples by reciprocal multiply, truncated toward zero
  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod_q;
  logic             neg_q;
  logic [QuotW-1:0] quot;

  assign mag  = accum_q[AccW-1] ? MagW'(-accum_q) : accum_q[MagW-1:0];
  assign quot = prod_q[Shift +: QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      prod_q      <= '0;
      neg_q       <= 1'b0;
      baseline_q  <= 16'sd16384;
    end else begin
      unique case (div_state_q)
        DIV_IDLE: begin
          if (in_fire && !calib_q && calib_done) begin
            div_state_q <= DIV_MUL;
          end
        end
        DIV_MUL: begin
          prod_q      <= ProdW'(mag) * ProdW'(Recip);
          neg_q       <= accum_q[AccW-1];
          div_state_q <= DIV_SCALE;
        end
        DIV_SCALE: begin
          baseline_q  <= neg_q ? SampleW'(-quot) : quot[SampleW-1:0];
          div_state_q <= DIV_IDLE;
        end
        default: div_state_q <= DIV_IDLE;
      endcase
    end
  end

  a_no_motion_before_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2] |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[1])
    else $error("motion reported before calibration");

  a_stall_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_state_q != DIV_IDLE |-> !s_axis_tready_o)
    else $error("input accepted while baseline not ready");

  a_change_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && changed_d |=> motion_q != $past(motion_q))
    else $error("state change flagged without toggle");

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calib_q |=> calib_q)
    else $error("calibration lost");

endmodule
